// ----- hdl/dehe_pkg.sv -----
package dehe_pkg;

  typedef enum logic [1:0] {
    PH_GLOBAL = 2'd0,
    PH_UNIT   = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_UNIT = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned RecBytes  = 6;

  // One queued byte's worth of work for the back end.
  typedef struct packed {
    logic        unit_rep;
    logic        end_rep;
    logic [7:0]  hit_mask;
    logic [1:0]  chan_hi;
    logic [3:0]  board;
    logic [2:0]  chip;
    logic [7:0]  unit;
    logic [15:0] hit_time;
    logic        fall;
    logic        warn;
    logic [15:0] event_id;
    logic [4:0]  overflow;
    logic [3:0]  gboard;
    logic        gfall;
    logic [16:0] total;
  } job_t;

endpackage

// ----- hdl/dehe_front.sv -----
module dehe_front #(
  parameter int unsigned UNITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  output logic            push_o,
  output dehe_pkg::job_t  job_o
);
  import dehe_pkg::*;

  localparam int unsigned UIW = $clog2(UNITS + 1);

  phase_e          phase_q, phase_d;
  logic [2:0]      bp_q, bp_d;
  logic [UIW-1:0]  idx_q, idx_d;
  logic [UIW-1:0]  idx_n;
  logic [13:0]     wl_q, wl_d;
  logic [13:0]     wl_m1;
  logic [15:0]     en_q, en_d;
  logic [63:0]     glob_q, glob_d;
  logic [7:0]      h0_q, h0_d;
  logic [7:0]      h1_q, h1_d;
  logic [15:0]     time_q, time_d;
  logic [1:0]      k;
  logic            fin;
  job_t            job;

  assign idx_n = idx_q + UIW'(1);
  assign wl_m1 = wl_q - 14'd1;
  assign k     = 2'(bp_q - 3'd2);

  always_comb begin
    phase_d = phase_q;
    bp_d    = bp_q;
    idx_d   = idx_q;
    wl_d    = wl_q;
    en_d    = en_q;
    glob_d  = glob_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    time_d  = time_q;
    fin     = 1'b0;

    job              = '0;
    job.board        = h0_q[6:3];
    job.chip         = h0_q[2:0];
    job.unit         = h1_q;
    job.hit_time     = time_q;
    job.fall         = data_byte_i[7];
    job.warn         = ~data_byte_i[6] & en_q[4'(idx_q)];
    job.chan_hi      = ~k;
    job.event_id     = glob_q[31:16];
    job.overflow     = glob_q[54:50];
    job.gboard       = glob_q[59:56];
    job.gfall        = glob_q[55];
    job.total        = glob_q[48:32];

    if (accept_i) begin
      case (phase_q)
        PH_GLOBAL: begin
          glob_d = {glob_q[55:0], data_byte_i};
          if (bp_q >= 3'(HdrBytes - 1)) begin
            en_d    = {glob_q[7:0], data_byte_i};
            phase_d = PH_UNIT;
            idx_d   = '0;
            bp_d    = '0;
          end else begin
            bp_d = bp_q + 3'd1;
          end
        end
        PH_UNIT: begin
          case (bp_q)
            3'd0: begin
              h0_d = data_byte_i;
              h1_d = '0;
            end
            3'd1: h1_d = data_byte_i;
            3'd2: begin
              job.unit_rep = 1'b1;
              wl_d         = {8'd0, data_byte_i[5:0]};
            end
            3'd3: wl_d = {wl_q[5:0], data_byte_i};
            default: ;
          endcase
          if (bp_q >= 3'(RecBytes - 1)) begin
            if (wl_q == '0) begin
              fin = 1'b1;
            end else begin
              phase_d = PH_DATA;
              bp_d    = '0;
            end
          end else begin
            bp_d = bp_q + 3'd1;
          end
        end
        PH_DATA: begin
          case (bp_q)
            3'd0: time_d = {data_byte_i, 8'd0};
            3'd1: time_d = {time_q[15:8], data_byte_i};
            default: job.hit_mask = ~data_byte_i;
          endcase
          if (bp_q >= 3'(RecBytes - 1)) begin
            wl_d = wl_m1;
            if (wl_m1 == '0) begin
              fin = 1'b1;
            end else begin
              bp_d = '0;
            end
          end else begin
            bp_d = bp_q + 3'd1;
          end
        end
        default: phase_d = PH_GLOBAL;
      endcase

      if (fin) begin
        bp_d = '0;
        if (idx_n >= UIW'(UNITS)) begin
          job.end_rep = 1'b1;
          phase_d     = PH_GLOBAL;
          idx_d       = '0;
        end else begin
          phase_d = PH_UNIT;
          idx_d   = idx_n;
        end
      end
    end
  end

  assign job_o  = job;
  assign push_o = accept_i & (job.unit_rep | job.end_rep | (|job.hit_mask));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GLOBAL;
      bp_q    <= '0;
      idx_q   <= '0;
      wl_q    <= '0;
      en_q    <= '0;
      glob_q  <= '0;
      h0_q    <= '0;
      h1_q    <= '0;
      time_q  <= '0;
    end else begin
      phase_q <= phase_d;
      bp_q    <= bp_d;
      idx_q   <= idx_d;
      wl_q    <= wl_d;
      en_q    <= en_d;
      glob_q  <= glob_d;
      h0_q    <= h0_d;
      h1_q    <= h1_d;
      time_q  <= time_d;
    end
  end

endmodule

// ----- hdl/dehe_queue.sv -----
module dehe_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dehe_pkg::job_t  job_i,
  output logic            full_o,
  output logic            head_valid_o,
  output dehe_pkg::job_t  head_o,
  input  logic            pop_i
);
  import dehe_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t           mem_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d;
  logic [PW-1:0]  rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o       = (cnt_q == CW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i & ~full_o;
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/dehe_back.sv -----
module dehe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  dehe_pkg::job_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [3:0]      board_o,
  output logic [2:0]      chip_o,
  output logic [7:0]      unit_o,
  output logic [4:0]      channel_o,
  output logic [15:0]     hit_time_o,
  output logic            fall_flag_o,
  output logic            shift_warning_o,
  output logic [15:0]     event_id_o,
  output logic [4:0]      overflow_count_o,
  output logic [16:0]     total_words_o,
  output logic            last_o
);
  import dehe_pkg::*;

  logic        started_q, started_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  mask, mask_n;
  logic [2:0]  bit_idx;
  logic        load;
  logic        out_valid_q;

  kind_e       kind_q, kind_d;
  logic [3:0]  board_q, board_d;
  logic [2:0]  chip_q, chip_d;
  logic [7:0]  unit_q, unit_d;
  logic [4:0]  chan_q, chan_d;
  logic [15:0] time_q, time_d;
  logic        fall_q, fall_d;
  logic        warn_q, warn_d;
  logic [15:0] evn_q;
  logic [4:0]  ovf_q;
  logic [16:0] total_q, total_d;
  logic        last_q, last_d;

  assign load   = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign mask   = started_q ? rem_q : head_i.hit_mask;
  assign mask_n = mask & (mask - 8'd1);

  always_comb begin
    bit_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mask[i]) bit_idx = 3'(i);
    end
  end

  always_comb begin
    kind_d    = KIND_HIT;
    board_d   = head_i.board;
    chip_d    = head_i.chip;
    unit_d    = head_i.unit;
    chan_d    = '0;
    time_d    = '0;
    fall_d    = 1'b0;
    warn_d    = 1'b0;
    total_d   = '0;
    last_d    = 1'b1;
    started_d = started_q;
    rem_d     = rem_q;
    pop_o     = 1'b0;
    if (head_i.unit_rep) begin
      kind_d = KIND_UNIT;
      fall_d = head_i.fall;
      warn_d = head_i.warn;
    end else if (mask != '0) begin
      chan_d = {head_i.chan_hi, bit_idx};
      time_d = head_i.hit_time;
      last_d = (mask_n == '0) & ~head_i.end_rep;
    end else begin
      kind_d  = KIND_END;
      board_d = head_i.gboard;
      chip_d  = '0;
      unit_d  = '0;
      fall_d  = head_i.gfall;
      total_d = head_i.total;
    end
    if (load) begin
      if (last_d) begin
        pop_o     = 1'b1;
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        rem_d     = mask_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      rem_q       <= '0;
    end else begin
      started_q <= started_d;
      rem_q     <= rem_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      board_q <= board_d;
      chip_q  <= chip_d;
      unit_q  <= unit_d;
      chan_q  <= chan_d;
      time_q  <= time_d;
      fall_q  <= fall_d;
      warn_q  <= warn_d;
      evn_q   <= head_i.event_id;
      ovf_q   <= head_i.overflow;
      total_q <= total_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign board_o          = board_q;
  assign chip_o           = chip_q;
  assign unit_o           = unit_q;
  assign channel_o        = chan_q;
  assign hit_time_o       = time_q;
  assign fall_flag_o      = fall_q;
  assign shift_warning_o  = warn_q;
  assign event_id_o       = evn_q;
  assign overflow_count_o = ovf_q;
  assign total_words_o    = total_q;
  assign last_o           = last_q;

endmodule

// ----- hdl/detector_event_hit_extractor.sv -----
// Channel  | Handshake                  | Payload
// input    | in_valid_i / in_stall_o    | data_byte_i
// output   | out_valid_o / out_stall_i  | kind_o .. last_o (one result per item)
//
// Input: one byte a cycle while the job queue (DEPTH entries) has room.
// Output: one result a cycle from the expander while out_stall_i is low; a queued
// byte pops with its last result (unit report 1, up to 8 hits, plus 1 for end).
// Bytes that cause no result never enter the queue.
// Reset clears parser state, queue pointers and the output valid; no sweep.
// in_stall_o is high exactly when the queue is full.
module detector_event_hit_extractor #(
  parameter int unsigned UNITS = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  board_o,
  output logic [2:0]  chip_o,
  output logic [7:0]  unit_o,
  output logic [4:0]  channel_o,
  output logic [15:0] hit_time_o,
  output logic        fall_flag_o,
  output logic        shift_warning_o,
  output logic [15:0] event_id_o,
  output logic [4:0]  overflow_count_o,
  output logic [16:0] total_words_o,
  output logic        last_o
);
  import dehe_pkg::*;

  logic  accept;
  logic  push, full, head_valid, pop;
  job_t  job, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  dehe_front #(.UNITS(UNITS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .data_byte_i,
    .push_o      (push),
    .job_o       (job)
  );

  dehe_queue #(.DEPTH(DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .job_i        (job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dehe_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .board_o,
    .chip_o,
    .unit_o,
    .channel_o,
    .hit_time_o,
    .fall_flag_o,
    .shift_warning_o,
    .event_id_o,
    .overflow_count_o,
    .total_words_o,
    .last_o
  );

endmodule

// ----- hdl/dehe_checker.sv -----
module dehe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic        fall_flag_o,
  input logic        shift_warning_o,
  input logic [16:0] total_words_o,
  input logic        last_o
);
  import dehe_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_HIT || kind_o == KIND_UNIT || kind_o == KIND_END))
    else $error("bad result kind");

  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HIT |-> !fall_flag_o && !shift_warning_o
      && total_words_o == '0)
    else $error("hit carries report fields");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_UNIT |-> last_o && total_words_o == '0)
    else $error("unit report not alone");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_END |-> last_o && !shift_warning_o)
    else $error("event end not last");

endmodule

bind detector_event_hit_extractor dehe_checker u_dehe_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .kind_o,
  .fall_flag_o,
  .shift_warning_o,
  .total_words_o,
  .last_o
);

// ----- tb/event_report_pkg.sv -----
package event_report_pkg;

  import dehe_pkg::*;

  localparam int unsigned EventUnits = 16;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  board;
    logic [2:0]  chip;
    logic [7:0]  unit;
    logic [4:0]  channel;
    logic [15:0] hit_time;
    logic        fall_flag;
    logic        shift_warning;
    logic [15:0] event_id;
    logic [4:0]  overflow_count;
    logic [16:0] total_words;
    logic        last;
  } hit_report_t;

  class event_report_board;
    hit_report_t expected[$];
    int unsigned errors;

    phase_e      phase;
    logic [2:0]  byte_pos;
    logic [4:0]  unit_idx;
    logic [13:0] words_left;
    logic [15:0] enable_mask;
    logic [7:0]  ghdr [8];
    logic [7:0]  uhdr0;
    logic [7:0]  uhdr1;
    logic [15:0] word_time;

    function new();
      errors      = 0;
      phase       = PH_GLOBAL;
      byte_pos    = '0;
      unit_idx    = '0;
      words_left  = '0;
      enable_mask = '0;
      foreach (ghdr[k]) ghdr[k] = '0;
      uhdr0       = '0;
      uhdr1       = '0;
      word_time   = '0;
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function string describe(hit_report_t r);
      return $sformatf({"kind=%0d board=%0d chip=%0d unit=%0d ch=%0d time=%h fall=%b",
                        " warn=%b evt=%h ovf=%0d total=%h last=%b"},
                       r.kind, r.board, r.chip, r.unit, r.channel, r.hit_time,
                       r.fall_flag, r.shift_warning, r.event_id, r.overflow_count,
                       r.total_words, r.last);
    endfunction

    function void add_report(kind_e kind, logic [3:0] board, logic [2:0] chip,
                             logic [7:0] unit, logic [4:0] channel, logic [15:0] tm,
                             logic fall, logic warn, logic [16:0] total);
      hit_report_t r;
      r.kind           = kind;
      r.board          = board;
      r.chip           = chip;
      r.unit           = unit;
      r.channel        = channel;
      r.hit_time       = tm;
      r.fall_flag      = fall;
      r.shift_warning  = warn;
      r.event_id       = {ghdr[4], ghdr[5]};
      r.overflow_count = ghdr[1][6:2];
      r.total_words    = total;
      r.last           = 1'b0;
      expected.insert(expected.size(), r);
    endfunction

    function void close_unit();
      unit_idx = unit_idx + 5'd1;
      byte_pos = '0;
      if (unit_idx >= EventUnits) begin
        add_report(KIND_END, ghdr[0][3:0], 3'd0, 8'd0, 5'd0, 16'd0, ghdr[1][7], 1'b0,
                   {ghdr[1][0], ghdr[2], ghdr[3]});
        phase    = PH_GLOBAL;
        unit_idx = '0;
      end else begin
        phase = PH_UNIT;
      end
    endfunction

    // Accepted input byte: advance the parser and queue the results it causes.
    function void note_byte(logic [7:0] b);
      int unsigned before_cnt;
      before_cnt = expected.size();
      case (phase)
        PH_GLOBAL: begin
          ghdr[byte_pos] = b;
          if (byte_pos == 3'd7) begin
            enable_mask = {ghdr[6], ghdr[7]};
            phase       = PH_UNIT;
            unit_idx    = '0;
            byte_pos    = '0;
          end else begin
            byte_pos++;
          end
        end
        PH_UNIT: begin
          case (byte_pos)
            3'd0: uhdr0 = b;
            3'd1: uhdr1 = b;
            3'd2: begin
              add_report(KIND_UNIT, uhdr0[6:3], uhdr0[2:0], uhdr1, 5'd0, 16'd0, b[7],
                         !b[6] && enable_mask[unit_idx[3:0]], 17'd0);
              words_left = 14'(b[5:0]);
            end
            3'd3: words_left = {words_left[5:0], b};
            default: ;
          endcase
          if (byte_pos == 3'd5) begin
            if (words_left == '0) begin
              close_unit();
            end else begin
              phase    = PH_DATA;
              byte_pos = '0;
            end
          end else begin
            byte_pos++;
          end
        end
        default: begin
          if (byte_pos == 3'd0) begin
            word_time[15:8] = b;
          end else if (byte_pos == 3'd1) begin
            word_time[7:0] = b;
          end else begin
            for (int i = 0; i < 8; i++) begin
              if (!b[i])
                add_report(KIND_HIT, uhdr0[6:3], uhdr0[2:0], uhdr1,
                           {2'(3'd5 - byte_pos), 3'(i)}, word_time, 1'b0, 1'b0, 17'd0);
            end
          end
          if (byte_pos == 3'd5) begin
            words_left = words_left - 14'd1;
            if (words_left == '0) close_unit();
            else byte_pos = '0;
          end else begin
            byte_pos++;
          end
        end
      endcase
      if (expected.size() > before_cnt) expected[$].last = 1'b1;
    endfunction

    function void check_result(hit_report_t got);
      hit_report_t want;
      if (expected.size() == 0) begin
        flag({"unexpected result ", describe(got)});
        return;
      end
      want = expected.pop_front();
      if (got !== want)
        flag({"result mismatch\n  expected ", describe(want), "\n  actual   ", describe(got)});
    endfunction
  endclass

endpackage

// ----- tb/detector_event_hit_extractor_test.sv -----
module detector_event_hit_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dehe_pkg::*;
  import event_report_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [3:0]  board_o;
  logic [2:0]  chip_o;
  logic [7:0]  unit_o;
  logic [4:0]  channel_o;
  logic [15:0] hit_time_o;
  logic        fall_flag_o;
  logic        shift_warning_o;
  logic [15:0] event_id_o;
  logic [4:0]  overflow_count_o;
  logic [16:0] total_words_o;
  logic        last_o;

  event_report_board sb = new();

  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned hold_req   = 0;

  detector_event_hit_extractor #(
    .UNITS(EventUnits)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .board_o          (board_o),
    .chip_o           (chip_o),
    .unit_o           (unit_o),
    .channel_o        (channel_o),
    .hit_time_o       (hit_time_o),
    .fall_flag_o      (fall_flag_o),
    .shift_warning_o  (shift_warning_o),
    .event_id_o       (event_id_o),
    .overflow_count_o (overflow_count_o),
    .total_words_o    (total_words_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    hit_report_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind           = kind_e'(kind_o);
        got.board          = board_o;
        got.chip           = chip_o;
        got.unit           = unit_o;
        got.channel        = channel_o;
        got.hit_time       = hit_time_o;
        got.fall_flag      = fall_flag_o;
        got.shift_warning  = shift_warning_o;
        got.event_id       = event_id_o;
        got.overflow_count = overflow_count_o;
        got.total_words    = total_words_o;
        got.last           = last_o;
        sb.check_result(got);
      end
    end
  end

  // receiver: random stall modes, plus a long hold on request
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned hold;
    logic        toggle;
    hold   = 0;
    toggle = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 80);
      repeat (run) begin
        @(posedge clk_i);
        if (hold_req > 0) begin
          hold     = hold_req;
          hold_req = 0;
        end
        toggle = ~toggle;
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          hold--;
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= toggle;
          endcase
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] tm, input logic [31:0] chans);
    send_byte(tm[15:8]);
    send_byte(tm[7:0]);
    send_byte(chans[31:24]);
    send_byte(chans[23:16]);
    send_byte(chans[15:8]);
    send_byte(chans[7:0]);
  endtask

  task automatic send_unit_header(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic fall, input logic ck,
                                  input logic [13:0] count,
                                  input logic [7:0] b4, input logic [7:0] b5);
    send_byte(b0);
    send_byte(b1);
    send_byte({fall, ck, count[13:8]});
    send_byte(count[7:0]);
    send_byte(b4);
    send_byte(b5);
  endtask

  function automatic logic [7:0] chan_byte(input bit sparse);
    case ($urandom_range(0, sparse ? 15 : 4))
      0: return 8'h00;
      1: return 8'($urandom_range(0, 255));
      2: return ~(8'h01 << $urandom_range(0, 7));
      default: return 8'hff;
    endcase
  endfunction

  // big_unit < 0: no unit with the full 14-bit count
  task automatic send_random_event(input int max_words, input int big_unit);
    int unsigned words;
    bit          sparse;
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    for (int u = 0; u < EventUnits; u++) begin
      sparse = (u == big_unit);
      if (sparse) words = 14'h3fff;
      else if ($urandom_range(0, 3) == 0) words = $urandom_range(0, max_words);
      else words = $urandom_range(0, 2);
      send_unit_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 14'(words),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      repeat (words)
        send_word(16'($urandom_range(0, 65535)),
                  {chan_byte(sparse), chan_byte(sparse), chan_byte(sparse),
                   chan_byte(sparse)});
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-ones header and mask; 32 hits in one word; 8 hits plus event end on one byte
    repeat (8) send_byte(8'hff);
    send_unit_header(8'hff, 8'hff, 1'b1, 1'b0, 14'd1, 8'hff, 8'hff);
    send_word(16'hffff, 32'h0000_0000);
    send_unit_header(8'h00, 8'h00, 1'b0, 1'b1, 14'd0, 8'h00, 8'h00);
    send_unit_header(8'h55, 8'haa, 1'b1, 1'b1, 14'd0, 8'h00, 8'hff);
    send_unit_header(8'haa, 8'h55, 1'b0, 1'b0, 14'd2, 8'h12, 8'h34);
    send_word(16'h0000, 32'hffff_ffff);
    send_word(16'h1234, 32'h7ffe_fdbf);
    for (int u = 4; u < EventUnits - 1; u++)
      send_unit_header(8'(u * 9), 8'(u), u[0], u[1], 14'd0, 8'h00, 8'h00);
    send_unit_header(8'h80, 8'h7f, 1'b0, 1'b0, 14'd1, 8'hff, 8'h00);
    send_word(16'h8001, 32'h0000_0000);

    // all-zero header, mask off; event end on the last header byte
    repeat (8) send_byte(8'h00);
    for (int u = 0; u < EventUnits; u++)
      send_unit_header(8'h00, 8'h00, 1'b0, 1'b0, 14'd0, 8'h00, 8'h00);
    drain();

    // long output hold while a hit-heavy event keeps coming
    hold_req = 400;
    send_random_event(2, -1);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.flag($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- detector_event_hit_extractor.f -----
hdl/dehe_pkg.sv
hdl/dehe_front.sv
hdl/dehe_queue.sv
hdl/dehe_back.sv
hdl/detector_event_hit_extractor.sv
hdl/dehe_checker.sv
tb/event_report_pkg.sv
tb/detector_event_hit_extractor_test.sv
